>>> design/rsrr_pkg.sv
// Package for the region rank-and-relabel block: widths, field offsets,
// transfer codes and the sequencer state type.
// No dependencies; used by design/rank_sort_region_relabel.sv.
package rsrr_pkg;

  localparam int MAX_REGIONS      = 64;
  localparam int IDX_W            = $clog2(MAX_REGIONS);
  localparam int CNT_W            = $clog2(MAX_REGIONS + 1);
  localparam int KEY_W            = 12;
  localparam int DVAL_W           = 7;
  localparam int POP_W            = 32;
  localparam int ORG_W            = 6;
  localparam int NIDX_W           = 6;
  localparam int ORD_W            = 7;
  localparam int ORDER_MAX_OFFSET = 6;

  // Input tdata layout, lowest field first.
  localparam int IN_KEY_LSB  = 0;
  localparam int IN_DVAL_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_POP_LSB  = IN_DVAL_LSB + DVAL_W;
  localparam int IN_ORG_LSB  = IN_POP_LSB + POP_W;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_RELABEL = 1'b1;
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_RELABEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELABEL,
    ST_RANK_ADDR,
    ST_RANK_KEY,
    ST_RANK_SCAN,
    ST_EMIT_ADDR,
    ST_EMIT_POS,
    ST_EMIT_OUT
  } state_t;

endpackage

>>> design/rank_sort_region_relabel.sv
// Region rank-and-relabel block: loads region records into memories, ranks
// them by ascending age key (stable), emits them in rank order, relabels ids.
// Depends on design/rsrr_pkg.sv.
//
//   Channel  Direction  Payload (lowest bit first)
//   s_*      in         tuser=func, tlast=last_region,
//                       tdata=order_key, region_dval, region_pop, old_region
//   m_*      out        tuser=kind, tlast=last,
//                       tdata=new_index, out_dval, out_pop, added_order,
//                       order_max, bad_id
//
// A load record is written into the memories when they have room. A relabel
// reads the rank memory, then fills the output register once it is free.
// The final record of a load starts the ranking pass. For n stored regions
// it runs n passes over the key memory (one memory read per comparison),
// then emits the records in rank order, each through a position memory
// read, then a record memory read, then the output register.
// Reset clears the sequencer, its indices, the region count, the ranking flag
// and the output valid; the memories hold nothing meaningful until a load writes them.
// The output register holds a result while m_tready is low, and the
// sequencer waits on it; no new input transfer is taken until the block
// is back in idle.

module rank_sort_region_relabel (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // order_key[11:0], region_dval[18:12], region_pop[50:19], old_region[56:51]
  input  logic [rsrr_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tlast,   // last_region
  input  logic                                 s_tuser,   // func
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // new_index[5:0], out_dval[12:6], out_pop[44:13], added_order[51:45],
  // order_max[58:52], bad_id[59]
  output logic [rsrr_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,   // last
  output logic                                 m_tuser    // kind
);

  localparam int IDX_W  = rsrr_pkg::IDX_W;
  localparam int CNT_W  = rsrr_pkg::CNT_W;
  localparam int KEY_W  = rsrr_pkg::KEY_W;
  localparam int DVAL_W = rsrr_pkg::DVAL_W;
  localparam int POP_W  = rsrr_pkg::POP_W;
  localparam int ORG_W  = rsrr_pkg::ORG_W;
  localparam int NIDX_W = rsrr_pkg::NIDX_W;
  localparam int ORD_W  = rsrr_pkg::ORD_W;
  localparam int DEPTH  = rsrr_pkg::MAX_REGIONS;

  // Input fields.
  logic [KEY_W-1:0]  in_key;
  logic [DVAL_W-1:0] in_dval;
  logic [POP_W-1:0]  in_pop;
  logic [ORG_W-1:0]  in_org;

  assign in_key  = s_tdata[rsrr_pkg::IN_KEY_LSB  +: KEY_W];
  assign in_dval = s_tdata[rsrr_pkg::IN_DVAL_LSB +: DVAL_W];
  assign in_pop  = s_tdata[rsrr_pkg::IN_POP_LSB  +: POP_W];
  assign in_org  = s_tdata[rsrr_pkg::IN_ORG_LSB  +: ORG_W];

  // Memories: keys, district counts, populations, rank per old id, and old
  // id per rank position.
  logic [KEY_W-1:0]  key_mem  [DEPTH];
  logic [DVAL_W-1:0] dval_mem [DEPTH];
  logic [POP_W-1:0]  pop_mem  [DEPTH];
  logic [IDX_W-1:0]  rank_mem [DEPTH];
  logic [IDX_W-1:0]  pos_mem  [DEPTH];

  logic [KEY_W-1:0]  key_q;
  logic [DVAL_W-1:0] dval_q;
  logic [POP_W-1:0]  pop_q;
  logic [IDX_W-1:0]  rank_q;
  logic [IDX_W-1:0]  pos_q;

  // Control state.
  rsrr_pkg::state_t  state, state_next;
  logic [CNT_W-1:0]  region_count;
  logic              ranked_valid;
  logic [IDX_W-1:0]  i_idx;      // region being ranked, or emit position
  logic [IDX_W-1:0]  j_idx;      // region whose key sits in key_q
  logic [IDX_W-1:0]  rank_acc;   // keys found ahead of region i so far
  logic [KEY_W-1:0]  key_i;
  logic              rl_ok;

  // Output register.
  logic              out_valid;
  logic              out_kind;
  logic [NIDX_W-1:0] out_idx;
  logic [DVAL_W-1:0] out_dval;
  logic [POP_W-1:0]  out_pop;
  logic [ORD_W-1:0]  out_added;
  logic [ORD_W-1:0]  out_omax;
  logic              out_bad;
  logic              out_last;

  // Datapath terms.
  logic              in_take;
  logic              load_go;
  logic              relabel_go;
  logic [CNT_W-1:0]  eff_count;
  logic              load_fits;
  logic [CNT_W-1:0]  count_after;
  logic [IDX_W-1:0]  n_last;
  logic              scan_hit;
  logic [IDX_W-1:0]  rank_fin;
  logic              scan_done;
  logic              out_free;

  assign in_take     = s_tvalid && s_tready;
  assign load_go     = in_take && (s_tuser == rsrr_pkg::FUNC_LOAD);
  assign relabel_go  = in_take && (s_tuser == rsrr_pkg::FUNC_RELABEL);
  // The first load after a finished ranking starts a fresh set.
  assign eff_count   = ranked_valid ? '0 : region_count;
  assign load_fits   = eff_count < CNT_W'(DEPTH);
  assign count_after = eff_count + CNT_W'(load_fits);
  assign n_last      = IDX_W'(region_count - CNT_W'(1));
  // Smaller key ranks ahead; an equal key ranks ahead if its old id is lower.
  assign scan_hit    = (key_q < key_i) || ((key_q == key_i) && (j_idx < i_idx));
  assign rank_fin    = rank_acc + IDX_W'(scan_hit);
  assign scan_done   = (j_idx == n_last);
  assign out_free    = !out_valid || m_tready;

  // Decoded controls.
  logic              key_re_scan;
  logic              rank_we;
  logic              pos_re;
  logic              rec_re;
  logic              out_load;
  logic [IDX_W-1:0]  key_raddr;

  always_comb begin
    s_tready    = 1'b0;
    key_re_scan = 1'b0;
    rank_we     = 1'b0;
    pos_re      = 1'b0;
    rec_re      = 1'b0;
    out_load    = 1'b0;
    key_raddr   = i_idx;
    case (state)
      rsrr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      rsrr_pkg::ST_RELABEL: begin
        out_load = out_free;
      end
      rsrr_pkg::ST_RANK_ADDR: begin
        key_raddr = i_idx;
      end
      rsrr_pkg::ST_RANK_KEY: begin
        key_raddr = '0;
      end
      rsrr_pkg::ST_RANK_SCAN: begin
        key_re_scan = 1'b1;
        key_raddr   = j_idx + IDX_W'(1);
        rank_we     = scan_done;
      end
      rsrr_pkg::ST_EMIT_ADDR: begin
        pos_re = 1'b1;
      end
      rsrr_pkg::ST_EMIT_POS: begin
        rec_re = 1'b1;
      end
      rsrr_pkg::ST_EMIT_OUT: begin
        out_load = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      rsrr_pkg::ST_IDLE: begin
        if (relabel_go) begin
          state_next = rsrr_pkg::ST_RELABEL;
        end else if (load_go && s_tlast) begin
          state_next = rsrr_pkg::ST_RANK_ADDR;
        end
      end
      rsrr_pkg::ST_RELABEL: begin
        if (out_free) begin
          state_next = rsrr_pkg::ST_IDLE;
        end
      end
      rsrr_pkg::ST_RANK_ADDR: begin
        state_next = rsrr_pkg::ST_RANK_KEY;
      end
      rsrr_pkg::ST_RANK_KEY: begin
        state_next = rsrr_pkg::ST_RANK_SCAN;
      end
      rsrr_pkg::ST_RANK_SCAN: begin
        if (scan_done) begin
          state_next = (i_idx == n_last) ? rsrr_pkg::ST_EMIT_ADDR
                                         : rsrr_pkg::ST_RANK_ADDR;
        end
      end
      rsrr_pkg::ST_EMIT_ADDR: begin
        state_next = rsrr_pkg::ST_EMIT_POS;
      end
      rsrr_pkg::ST_EMIT_POS: begin
        state_next = rsrr_pkg::ST_EMIT_OUT;
      end
      rsrr_pkg::ST_EMIT_OUT: begin
        if (out_free) begin
          state_next = (i_idx == n_last) ? rsrr_pkg::ST_IDLE
                                         : rsrr_pkg::ST_EMIT_ADDR;
        end
      end
      default: begin
        state_next = rsrr_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (load_go && load_fits) begin
      key_mem[eff_count[IDX_W-1:0]]  <= in_key;
      dval_mem[eff_count[IDX_W-1:0]] <= in_dval;
      pop_mem[eff_count[IDX_W-1:0]]  <= in_pop;
    end
    key_q <= key_mem[key_raddr];
    if (rec_re) begin
      dval_q <= dval_mem[pos_q];
      pop_q  <= pop_mem[pos_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[i_idx]  <= rank_fin;
      pos_mem[rank_fin] <= i_idx;
    end
    if (relabel_go) begin
      rank_q <= rank_mem[in_org[IDX_W-1:0]];
    end
    if (pos_re) begin
      pos_q <= pos_mem[i_idx];
    end
  end

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rsrr_pkg::ST_IDLE;
      region_count <= '0;
      ranked_valid <= 1'b0;
      i_idx        <= '0;
      j_idx        <= '0;
      rank_acc     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (load_go) begin
        region_count <= count_after;
        ranked_valid <= 1'b0;
        i_idx        <= '0;
      end
      if (relabel_go) begin
        rl_ok <= ranked_valid && ({1'b0, in_org} < region_count);
      end
      if (state == rsrr_pkg::ST_RANK_KEY) begin
        key_i    <= key_q;
        j_idx    <= '0;
        rank_acc <= '0;
      end
      if (key_re_scan) begin
        j_idx    <= j_idx + IDX_W'(1);
        rank_acc <= rank_fin;
        if (scan_done) begin
          i_idx <= (i_idx == n_last) ? '0 : i_idx + IDX_W'(1);
        end
      end
      if ((state == rsrr_pkg::ST_EMIT_OUT) && out_free) begin
        i_idx <= i_idx + IDX_W'(1);
        if (i_idx == n_last) begin
          ranked_valid <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == rsrr_pkg::ST_RELABEL) begin
        out_kind  <= rsrr_pkg::KIND_RELABEL;
        out_idx   <= rl_ok ? NIDX_W'(rank_q) : '0;
        out_dval  <= '0;
        out_pop   <= '0;
        out_added <= '0;
        out_omax  <= '0;
        out_bad   <= !rl_ok;
        out_last  <= 1'b1;
      end else begin
        out_kind  <= rsrr_pkg::KIND_RECORD;
        out_idx   <= NIDX_W'(i_idx);
        out_dval  <= dval_q;
        out_pop   <= pop_q;
        out_added <= ORD_W'(i_idx) + ORD_W'(1);
        out_omax  <= ORD_W'(region_count) + ORD_W'(rsrr_pkg::ORDER_MAX_OFFSET);
        out_bad   <= 1'b0;
        out_last  <= (i_idx == n_last);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'b0, out_bad, out_omax, out_added, out_pop, out_dval, out_idx};

  // The scan counts at most one hit per key already compared.
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rsrr_pkg::ST_RANK_SCAN) |-> (rank_acc <= j_idx))
    else $error("rank count ran ahead of the scan");

  // Ranking never starts on an empty set.
  a_rank_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == rsrr_pkg::ST_RANK_ADDR) |-> (region_count != '0))
    else $error("ranking started with no regions stored");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    region_count <= CNT_W'(DEPTH))
    else $error("region count above memory depth");

  // A ranking becomes valid exactly as its last record is presented.
  a_valid_with_last: assert property (@(posedge clk) disable iff (rst)
    $rose(ranked_valid) |-> (out_valid && out_last && (out_kind == rsrr_pkg::KIND_RECORD)))
    else $error("ranking marked valid without its last record");

  a_record_good: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == rsrr_pkg::KIND_RECORD)) |-> !out_bad)
    else $error("reordered record flagged as bad id");

endmodule

>>> sim/rank_sort_region_relabel_test.sv
// Self-checking testbench for the region rank-and-relabel block.
// It drives the input stream, predicts the ranked and relabeled results, and checks them.
// Depends on design/rsrr_pkg.sv and design/rank_sort_region_relabel.sv.
module rank_sort_region_relabel_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REGIONS      = rsrr_pkg::MAX_REGIONS;
  localparam int IDX_W            = rsrr_pkg::IDX_W;
  localparam int KEY_W            = rsrr_pkg::KEY_W;
  localparam int DVAL_W           = rsrr_pkg::DVAL_W;
  localparam int POP_W            = rsrr_pkg::POP_W;
  localparam int ORG_W            = rsrr_pkg::ORG_W;
  localparam int NIDX_W           = rsrr_pkg::NIDX_W;
  localparam int ORD_W            = rsrr_pkg::ORD_W;
  localparam int ORDER_MAX_OFFSET = rsrr_pkg::ORDER_MAX_OFFSET;
  localparam int IN_KEY_LSB       = rsrr_pkg::IN_KEY_LSB;
  localparam int IN_DVAL_LSB      = rsrr_pkg::IN_DVAL_LSB;
  localparam int IN_POP_LSB       = rsrr_pkg::IN_POP_LSB;
  localparam int IN_ORG_LSB       = rsrr_pkg::IN_ORG_LSB;
  localparam int IN_DATA_W        = rsrr_pkg::IN_DATA_W;
  localparam int OUT_DATA_W       = rsrr_pkg::OUT_DATA_W;

  // The output tdata layout, lowest field first. It matches the comment on the m_tdata port.
  localparam int OUT_NIDX_LSB  = 0;
  localparam int OUT_DVAL_LSB  = OUT_NIDX_LSB + NIDX_W;
  localparam int OUT_POP_LSB   = OUT_DVAL_LSB + DVAL_W;
  localparam int OUT_ADDED_LSB = OUT_POP_LSB + POP_W;
  localparam int OUT_OMAX_LSB  = OUT_ADDED_LSB + ORD_W;
  localparam int OUT_BAD_LSB   = OUT_OMAX_LSB + ORD_W;

  // Stimulus stops once about this many input transfers have been made.
  localparam int ITEM_TARGET = 410;
  // The slowest stretch with no transfer is a full 64-region ranking, followed by the
  // longest receiver stall. The limit allows several times that.
  localparam int IDLE_LIMIT  = 20000;
  // This many cycles pass after the last expected result, so that a stray late result
  // is still caught.
  localparam int TAIL_CYCLES = 64;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tlast;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  // One expected output transfer, with the fields at the block's widths.
  typedef struct {
    logic              kind;
    logic [NIDX_W-1:0] new_index;
    logic [DVAL_W-1:0] dval;
    logic [POP_W-1:0]  pop;
    logic [ORD_W-1:0]  added;
    logic [ORD_W-1:0]  omax;
    logic              bad;
    logic              last;
  } region_result_t;

  // The scoreboard keeps its own copy of the region stores and of the rank map. It
  // turns each accepted input transfer into the results that the block owes, and it
  // checks the output transfers against them in order.
  class rank_scoreboard;
    logic [KEY_W-1:0]  key_mem  [MAX_REGIONS];
    logic [DVAL_W-1:0] dval_mem [MAX_REGIONS];
    logic [POP_W-1:0]  pop_mem  [MAX_REGIONS];
    logic [IDX_W-1:0]  rank_mem [MAX_REGIONS];
    int unsigned       stored = 0;
    bit                ranked = 0;
    region_result_t    expected_q[$];
    int                errors = 0;
    int                checked = 0;
    int                n_loads = 0;
    int                n_relabels = 0;
    int                n_rankings = 0;
    int                n_dropped = 0;
    int                max_ranked = 0;

    function int pending();
      return expected_q.size();
    endfunction

    // This is a stable ranking. A region's new position is the number of regions whose
    // key is lower, plus the number of regions with an equal key and a lower old index.
    function void rank_regions();
      int unsigned    order_of [MAX_REGIONS];
      int unsigned    r;
      region_result_t res;
      for (int unsigned i = 0; i < stored; i++) begin
        r = 0;
        for (int unsigned j = 0; j < stored; j++) begin
          if (key_mem[j] < key_mem[i] || (key_mem[j] == key_mem[i] && j < i)) r++;
        end
        rank_mem[i] = r[IDX_W-1:0];
        order_of[r] = i;
      end
      for (int unsigned p = 0; p < stored; p++) begin
        res.kind      = rsrr_pkg::KIND_RECORD;
        res.new_index = p[NIDX_W-1:0];
        res.dval      = dval_mem[order_of[p]];
        res.pop       = pop_mem[order_of[p]];
        res.added     = ORD_W'(p + 1);
        res.omax      = ORD_W'(stored + ORDER_MAX_OFFSET);
        res.bad       = 1'b0;
        res.last      = (p + 1 == stored);
        expected_q.push_back(res);
      end
      ranked = 1;
      n_rankings++;
      if (stored > max_ranked) max_ranked = stored;
    endfunction

    function void note_input(logic func, logic [KEY_W-1:0] key, logic [DVAL_W-1:0] dval,
                             logic [POP_W-1:0] pop, logic lastr, logic [ORG_W-1:0] org);
      region_result_t res;
      if (func == rsrr_pkg::FUNC_LOAD) begin
        n_loads++;
        // The first record after a completed ranking starts a fresh load.
        if (ranked) begin
          ranked = 0;
          stored = 0;
        end
        if (stored < MAX_REGIONS) begin
          key_mem[stored]  = key;
          dval_mem[stored] = dval;
          pop_mem[stored]  = pop;
          stored++;
        end else begin
          n_dropped++;
        end
        // The final record closes the load, even when overflow dropped it.
        if (lastr) rank_regions();
      end else begin
        n_relabels++;
        res = '{kind: rsrr_pkg::KIND_RELABEL, new_index: '0, dval: '0, pop: '0, added: '0,
                omax: '0, bad: 1'b1, last: 1'b1};
        if (ranked && org < stored) begin
          res.new_index = rank_mem[org];
          res.bad       = 1'b0;
        end
        expected_q.push_back(res);
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 30)
        $display("Mismatch at result %0d, %s: got %0h, expected %0h", checked, what, got,
                 want);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data, logic tl, logic tu);
      region_result_t want;
      if (expected_q.size() == 0) begin
        report("transfer with nothing expected", data, '0);
      end else begin
        want = expected_q.pop_front();
        if (tu !== want.kind) report("kind", 64'(tu), 64'(want.kind));
        if (data[OUT_NIDX_LSB +: NIDX_W] !== want.new_index)
          report("new_index", 64'(data[OUT_NIDX_LSB +: NIDX_W]), 64'(want.new_index));
        if (data[OUT_DVAL_LSB +: DVAL_W] !== want.dval)
          report("out_dval", 64'(data[OUT_DVAL_LSB +: DVAL_W]), 64'(want.dval));
        if (data[OUT_POP_LSB +: POP_W] !== want.pop)
          report("out_pop", 64'(data[OUT_POP_LSB +: POP_W]), 64'(want.pop));
        if (data[OUT_ADDED_LSB +: ORD_W] !== want.added)
          report("added_order", 64'(data[OUT_ADDED_LSB +: ORD_W]), 64'(want.added));
        if (data[OUT_OMAX_LSB +: ORD_W] !== want.omax)
          report("order_max", 64'(data[OUT_OMAX_LSB +: ORD_W]), 64'(want.omax));
        if (data[OUT_BAD_LSB] !== want.bad)
          report("bad_id", 64'(data[OUT_BAD_LSB]), 64'(want.bad));
        if (tl !== want.last) report("last", 64'(tl), 64'(want.last));
      end
      checked++;
    endtask
  endclass

  rank_scoreboard sb;
  int             items_sent = 0;
  int             burst_left = 0;
  int             ready_left = 0;

  rank_sort_region_relabel i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The sender offers one item and holds it until it is accepted. Items go out in
  // bursts of random length. A burst ends with a random gap, and a gap of zero keeps
  // tvalid high across the burst boundary. The valid is lowered only for a nonzero
  // gap before it is raised again.
  task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                           input logic [DVAL_W-1:0] dval, input logic [POP_W-1:0] pop,
                           input logic lastr, input logic [ORG_W-1:0] org);
    int                   gap;
    logic [IN_DATA_W-1:0] data;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    data = '0;
    data[IN_KEY_LSB +: KEY_W]   = key;
    data[IN_DVAL_LSB +: DVAL_W] = dval;
    data[IN_POP_LSB +: POP_W]   = pop;
    data[IN_ORG_LSB +: ORG_W]   = org;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= lastr;
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(func, key, dval, pop, lastr, org);
    items_sent++;
  endtask

  // A load record carries a random old_region, which the block ignores. This keeps
  // the bits of that field moving on every kind of transfer.
  task automatic send_load(input logic [KEY_W-1:0] key, input logic [DVAL_W-1:0] dval,
                           input logic [POP_W-1:0] pop, input logic lastr);
    send_item(rsrr_pkg::FUNC_LOAD, key, dval, pop, lastr, ORG_W'($urandom_range(0, 63)));
  endtask

  // A relabel carries random content in the load fields. These fields must not matter.
  task automatic send_relabel(input logic [ORG_W-1:0] org);
    send_item(rsrr_pkg::FUNC_RELABEL, KEY_W'($urandom), DVAL_W'($urandom_range(0, 64)),
              $urandom, 1'($urandom_range(0, 1)), org);
  endtask

  // This loads n random records and marks the last one. A small key span packs the
  // keys close together, so that many keys are equal.
  task automatic load_set(input int n, input int key_span);
    logic [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      key = (key_span == 0) ? KEY_W'($urandom_range(0, 4095))
                            : KEY_W'($urandom_range(0, key_span));
      send_load(key, DVAL_W'($urandom_range(0, 64)), $urandom, i == n - 1);
    end
  endtask

  // The sender holds off until the block has delivered every result that it owes.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The receiver checks every accepted output transfer. It stalls on its own pattern:
  // short or long stalls, between ready runs that are short or long.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_left = 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
      if (ready_left == 0) begin
        if (m_tready) begin
          m_tready <= 1'b0;
          ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 3);
        end else begin
          m_tready <= 1'b1;
          ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 6);
        end
      end else begin
        ready_left--;
      end
    end
  end

  // The watchdog ends the run when no transfer has happened on either side for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int scen;
    int pick;
    int n;
    int span;
    sb = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    s_tuser  <= rsrr_pkg::FUNC_LOAD;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // A relabel before any ranking has been done is a bad id.
    send_relabel(ORG_W'(0));
    send_relabel(ORG_W'(63));
    // This load holds three regions with the extreme keys and field values. Two of the
    // keys are equal, so the lower old index must rank first.
    send_load(12'hFFF, 7'd64, 32'hFFFF_FFFF, 1'b0);
    send_load(12'h000, 7'd0, 32'h0000_0000, 1'b0);
    send_load(12'hFFF, 7'd63, 32'h5A5A_5A5A, 1'b1);
    // There are valid ids, then ids that are not below the count.
    send_relabel(ORG_W'(0));
    send_relabel(ORG_W'(1));
    send_relabel(ORG_W'(2));
    send_relabel(ORG_W'(3));
    send_relabel(ORG_W'(63));
    // The sender holds off until all of the results above have arrived.
    drain_results();
    // A load of a single region gives the smallest order maximum.
    send_load(12'd7, 7'd1, 32'd1, 1'b1);
    send_relabel(ORG_W'(0));
    send_relabel(ORG_W'(1));
    // A relabel while a load is still open is a bad id. The open load had cleared the
    // previous ranking.
    send_load(12'd100, 7'd5, 32'hDEAD_BEEF, 1'b0);
    send_relabel(ORG_W'(0));
    send_load(12'd100, 7'd6, 32'h1234_5678, 1'b1);
    send_relabel(ORG_W'(1));
    send_relabel(ORG_W'(0));
    // These keys sit either side of the middle of the key range. Two of them are equal
    // and far apart in old index.
    send_load(12'h800, 7'h2A, 32'hAAAA_AAAA, 1'b0);
    send_load(12'h7FF, 7'h55, 32'h5555_5555, 1'b0);
    send_load(12'h001, 7'h40, 32'h8000_0001, 1'b0);
    send_load(12'h800, 7'h3F, 32'h7FFF_FFFE, 1'b1);
    send_relabel(ORG_W'(3));
    send_relabel(ORG_W'(0));

    // ---- Random part ----
    scen = 0;
    while (items_sent < ITEM_TARGET) begin
      scen++;
      if (scen == 6) begin
        // This fills the stores exactly. It gives the largest position, added order and
        // order maximum.
        load_set(MAX_REGIONS, 0);
        send_relabel(ORG_W'(63));
        send_relabel(ORG_W'($urandom_range(0, 63)));
      end else if (scen == 20) begin
        // Overflow: two records beyond the stores are dropped. The last of them still
        // closes the load.
        load_set(MAX_REGIONS + 2, 15);
        send_relabel(ORG_W'($urandom_range(0, 63)));
        send_relabel(ORG_W'(0));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // This is a well-formed load followed by relabels. Most of the relabel ids
          // are in range.
          n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          span = ($urandom_range(0, 2) == 0) ? 3 : 0;
          load_set(n, span);
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0) send_relabel(ORG_W'($urandom_range(0, 63)));
            else send_relabel(ORG_W'($urandom_range(0, n - 1)));
          end
        end else if (pick < 75) begin
          // These are stray relabels with any id.
          repeat ($urandom_range(1, 3)) send_relabel(ORG_W'($urandom_range(0, 63)));
        end else begin
          // This load is broken up by relabels that arrive while it is still open.
          repeat ($urandom_range(1, 4))
            send_load(KEY_W'($urandom_range(0, 4095)), DVAL_W'($urandom_range(0, 64)),
                      $urandom, 1'b0);
          repeat ($urandom_range(1, 2)) send_relabel(ORG_W'($urandom_range(0, 7)));
          load_set($urandom_range(1, 3), 7);
          send_relabel(ORG_W'($urandom_range(0, 7)));
        end
      end
      if (scen % 12 == 0) drain_results();
    end

    // The run ends when every result has arrived and a quiet tail has passed.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d load records, %0d relabels and %0d rankings; the largest had %0d.",
             sb.n_loads, sb.n_relabels, sb.n_rankings, sb.max_ranked);
    $display("Overflow dropped %0d records; %0d results checked, %0d mismatches.",
             sb.n_dropped, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
